// ===== rtl/life_generation_row_engine_unit_macros.svh =====
// assertion helpers used by the output queue
`ifndef LIFE_GENERATION_ROW_ENGINE_UNIT_MACROS_SVH
`define LIFE_GENERATION_ROW_ENGINE_UNIT_MACROS_SVH

// property that must hold at every rising clock edge outside reset
`define LGE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define LGE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lge_pkg.sv =====
package lge_pkg;

    // fixed widths of the stream fields and the width register
    localparam int ROW_BITS   = 64;
    localparam int WIDTH_BITS = 7;
    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 7'd64;

    // output queue size: holds a waiting beat plus the two beats of a last row
    localparam int QDEPTH   = 3;
    localparam int QCNT_BITS = 2;

    // masked cell bits one column hands to its neighbours
    typedef struct packed {
        logic upper;
        logic middle;
        logic cur;
    } lge_nbr_t;

    // one result beat
    typedef struct packed {
        logic                last;
        logic [ROW_BITS-1:0] bits;
    } lge_item_t;

    // which results an accepted row produces
    typedef struct packed {
        logic mid_row;
        logic last_row;
    } lge_push_t;

    // count of live bits among eight neighbours
    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] sum;
        sum = 4'd0;
        for (int i = 0; i < 8; i++) begin
            sum = sum + {3'b000, v[i]};
        end
        return sum;
    endfunction

endpackage

// ===== rtl/life_generation_row_engine_unit.sv =====
// One generation of Life (B3/S23) over a grid streamed one row per beat, top row first.
// A row of cells, one per column, holds the two previous rows; the next generation
// of the middle row leaves as soon as the row below it is accepted, so output runs
// one row behind input, and the bottom row (s_axis_tlast) releases two beats, the
// second with m_axis_tlast set. A one-row frame gives a single beat. The engine takes
// one row per clock: the result is written the same cycle into a three-beat output
// queue, and a row is accepted whenever at most one beat waits there, so with the
// output always ready only the row after a bottom row is held back.
// row_width, written through cfg_wr_en/cfg_wr_data (the user must write it only while no
// result beat is pending; the block does not enforce this), sets the live columns and applies
// at once, to held rows as well; columns at or above it or MAX_WIDTH are dead and read back as zero.
module life_generation_row_engine_unit
    import lge_pkg::*;
#(
    parameter int MAX_WIDTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [WIDTH_BITS-1:0] cfg_wr_data,    // row_width
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [ROW_BITS-1:0]   s_axis_tdata,   // [63:0] row_bits
    input  logic                  s_axis_tlast,   // last_row
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [ROW_BITS-1:0]   m_axis_tdata,   // [63:0] next_bits
    output logic                  m_axis_tlast    // frame_end
);

    logic [WIDTH_BITS-1:0] width_reg;
    logic                  have_mid_reg, have_mid_next;
    logic                  in_acc;
    logic [MAX_WIDTH-1:0]  live;
    logic [MAX_WIDTH-1:0]  res_mid;
    logic [MAX_WIDTH-1:0]  res_last;
    lge_nbr_t              own [MAX_WIDTH];
    lge_push_t             push;
    lge_item_t             item_mid;
    lge_item_t             item_last;
    logic                  room_two;

    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = room_two;

    // width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            width_reg <= cfg_wr_data;
        end
    end

    // a middle row is held once a frame has begun
    assign have_mid_next = in_acc ? !s_axis_tlast : have_mid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_mid_reg <= 1'b0;
        end
        else
        begin
            have_mid_reg <= have_mid_next;
        end
    end

    // row of column cells, each wired to its left and right neighbour
    for (genvar c = 0; c < MAX_WIDTH; c++)
    begin : g_col
        localparam logic [WIDTH_BITS-1:0] COL = WIDTH_BITS'(c);
        lge_nbr_t left_n;
        lge_nbr_t right_n;

        assign live[c] = (width_reg > COL);

        if (c == 0)
        begin : g_left_edge
            assign left_n = '0;
        end
        else
        begin : g_left
            assign left_n = own[c-1];
        end

        if (c == MAX_WIDTH - 1)
        begin : g_right_edge
            assign right_n = '0;
        end
        else
        begin : g_right
            assign right_n = own[c+1];
        end

        lge_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .load     (in_acc),
            .last     (s_axis_tlast),
            .live     (live[c]),
            .cur_bit  (s_axis_tdata[c]),
            .left     (left_n),
            .right    (right_n),
            .own      (own[c]),
            .res_mid  (res_mid[c]),
            .res_last (res_last[c])
        );
    end

    // result beats of the accepted row
    assign push.mid_row  = in_acc & have_mid_reg;
    assign push.last_row = in_acc & s_axis_tlast;
    assign item_mid.bits  = ROW_BITS'(res_mid);
    assign item_mid.last  = 1'b0;
    assign item_last.bits = ROW_BITS'(res_last);
    assign item_last.last = 1'b1;

    lge_out_queue u_queue (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .item_mid      (item_mid),
        .item_last     (item_last),
        .room_two      (room_two),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== rtl/lge_cell.sv =====
module lge_cell
    import lge_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  logic     last,
    input  logic     live,
    input  logic     cur_bit,
    input  lge_nbr_t left,
    input  lge_nbr_t right,
    output lge_nbr_t own,
    output logic     res_mid,
    output logic     res_last
);

    logic upper_reg, upper_next;
    logic middle_reg, middle_next;
    logic [3:0] cnt_mid;
    logic [3:0] cnt_last;

    // cells beyond the live width read as dead
    assign own.upper  = upper_reg & live;
    assign own.middle = middle_reg & live;
    assign own.cur    = cur_bit & live;

    // neighbour counts for the middle row and for the incoming row
    assign cnt_mid = popcount8({left.upper, own.upper, right.upper,
                                left.middle, right.middle,
                                left.cur, own.cur, right.cur});
    assign cnt_last = popcount8({left.middle, own.middle, right.middle,
                                 left.cur, right.cur, 3'b000});

    // born on three, survives on two or three
    assign res_mid  = live & ((cnt_mid == 4'd3) | (own.middle & (cnt_mid == 4'd2)));
    assign res_last = live & ((cnt_last == 4'd3) | (own.cur & (cnt_last == 4'd2)));

    // shift the column up by one row, clear at the end of a frame
    always_comb
    begin
        upper_next  = upper_reg;
        middle_next = middle_reg;
        if (load)
        begin
            if (last)
            begin
                upper_next  = 1'b0;
                middle_next = 1'b0;
            end
            else
            begin
                upper_next  = own.middle;
                middle_next = own.cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg  <= 1'b0;
            middle_reg <= 1'b0;
        end
        else
        begin
            upper_reg  <= upper_next;
            middle_reg <= middle_next;
        end
    end

endmodule

// ===== rtl/lge_out_queue.sv =====
`include "life_generation_row_engine_unit_macros.svh"

module lge_out_queue
    import lge_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  lge_push_t           push,
    input  lge_item_t           item_mid,
    input  lge_item_t           item_last,
    output logic                room_two,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [ROW_BITS-1:0] m_axis_tdata,
    output logic                m_axis_tlast
);

    lge_item_t q_reg [QDEPTH];
    lge_item_t q_next [QDEPTH];
    logic [QCNT_BITS-1:0] cnt_reg, cnt_next;
    logic pop;

    assign pop           = m_axis_tvalid & m_axis_tready;
    assign m_axis_tvalid = (cnt_reg != '0);
    assign m_axis_tdata  = q_reg[0].bits;
    assign m_axis_tlast  = q_reg[0].last;
    // space for the two beats of a last row
    assign room_two      = (cnt_reg <= QCNT_BITS'(QDEPTH - 2));

    // shift out the head beat, then append new beats behind the rest
    always_comb
    begin
        logic [QCNT_BITS-1:0] fill;
        fill = cnt_reg;
        for (int i = 0; i < QDEPTH; i++)
        begin
            q_next[i] = q_reg[i];
        end
        if (pop)
        begin
            for (int i = 0; i < QDEPTH - 1; i++)
            begin
                q_next[i] = q_reg[i+1];
            end
            fill = fill - 1'b1;
        end
        if (push.mid_row)
        begin
            for (int i = 0; i < QDEPTH; i++)
            begin
                if (fill == QCNT_BITS'(i))
                begin
                    q_next[i] = item_mid;
                end
            end
            fill = fill + 1'b1;
        end
        if (push.last_row)
        begin
            for (int i = 0; i < QDEPTH; i++)
            begin
                if (fill == QCNT_BITS'(i))
                begin
                    q_next[i] = item_last;
                end
            end
            fill = fill + 1'b1;
        end
        cnt_next = fill;
    end

    // beat storage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    `LGE_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= QCNT_BITS'(QDEPTH), "queue count out of range")
    `LGE_ASSERT_ALWAYS(a_two_fit, !(push.mid_row && push.last_row) || cnt_reg <= 2'd1 || pop,
        "two beats pushed without room")
    `LGE_ASSERT_NEXT(a_no_drop, !pop, cnt_reg >= $past(cnt_reg), "beat lost without handshake")

endmodule
